@@ rtl/ckc_pkg.sv @@
// ckc_pkg: constants, key profile tables, fsm and command types for the
// chroma key correlator; no dependencies
package ckc_pkg;

    localparam int BIN_WIDTH = 16;
    localparam int NUM_BINS  = 12;
    localparam int IDX_W     = 4;
    localparam int SUM_W     = BIN_WIDTH + 4;
    localparam int SQ_W      = 2 * BIN_WIDTH + 4;
    localparam int VAR_W     = SQ_W + 4;
    localparam int HALF_W    = VAR_W / 2;
    localparam int Y_W       = 14;
    localparam int D_W       = 28;
    localparam int M_W       = D_W + VAR_W;
    localparam int N_W       = BIN_WIDTH + Y_W + 4;
    localparam int NABS_W    = N_W - 2;
    localparam int LO_W      = 16;
    localparam int SRCH_W    = 2 * BIN_WIDTH + 72;
    localparam int SCORE_W   = 16;
    localparam int RANK_W    = SCORE_W + 1;
    localparam int W_W       = 24;
    localparam int Q_W       = 40;
    localparam int X_W       = 22;
    localparam int CONF_W    = 16;
    localparam int RCP_W     = 19;

    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_BINS - 1);
    localparam logic [IDX_W-1:0] CNT_MAX    = IDX_W'(NUM_BINS + 1);
    localparam logic [IDX_W-1:0] DV_LAST    = 4'd3;
    localparam logic [IDX_W-1:0] SRCH_LAST  = IDX_W'(LO_W - 1);

    localparam logic [X_W-1:0]   CONF_SAT_X = 22'd327675;
    localparam logic [RCP_W-1:0] RECIP5     = 19'd419431;
    localparam logic [Q_W-1:0]   CONF_HALF  = 40'd163840;
    localparam logic signed [RANK_W-1:0] RANK_MIN = -17'sd65536;

    localparam logic [9:0] PROF_MAJ [NUM_BINS] = '{
        10'd635, 10'd223, 10'd348, 10'd233, 10'd438, 10'd409,
        10'd252, 10'd519, 10'd239, 10'd366, 10'd229, 10'd288
    };
    localparam logic [9:0] PROF_MIN [NUM_BINS] = '{
        10'd633, 10'd268, 10'd352, 10'd538, 10'd260, 10'd353,
        10'd254, 10'd475, 10'd398, 10'd269, 10'd334, 10'd317
    };
    localparam logic [12:0] PSUM_MAJ = 13'd4179;
    localparam logic [12:0] PSUM_MIN = 13'd4451;

    function automatic logic signed [Y_W-1:0] prof_y(input logic mode,
                                                     input logic [IDX_W-1:0] idx);
        logic [9:0]     p;
        logic [12:0]    s;
        logic [Y_W-1:0] t;
        p = mode ? PROF_MIN[idx] : PROF_MAJ[idx];
        s = mode ? PSUM_MIN : PSUM_MAJ;
        t = Y_W'(p) * Y_W'(12) - Y_W'(s);
        return $signed(t);
    endfunction

    function automatic logic [D_W-1:0] prof_d(input logic mode);
        logic [D_W-1:0]        acc;
        logic signed [D_W-1:0] y;
        acc = '0;
        for (int i = 0; i < NUM_BINS; i++) begin
            y   = D_W'(prof_y(mode, IDX_W'(i)));
            acc = acc + D_W'(y * y);
        end
        return acc;
    endfunction

    localparam logic [D_W-1:0] D_MAJ = prof_d(1'b0);
    localparam logic [D_W-1:0] D_MIN = prof_d(1'b1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQR, ST_VAR, ST_DV, ST_MAC, ST_NSQ,
        ST_XINIT, ST_SRCH, ST_RANK, ST_CONF, ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_EMPTY, OP_SQR, OP_VAR, OP_DV, OP_MAC,
        OP_NSQ, OP_XINIT, OP_SRCH, OP_RANK, OP_CONF, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] yidx;
        logic             wr;
        logic             first;
        logic             mode;
        logic [IDX_W-1:0] root;
    } t_cmd;

endpackage

@@ rtl/ckc_ctrl.sv @@
// ckc_ctrl: sequencer for bin loading, the 24 key correlations and the result
// depends on ckc_pkg
module ckc_ctrl import ckc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_last_bin,
    output logic o_busy,
    output t_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, r_idx, r_root, r_step;
    logic             r_mode;
    logic             accept;
    logic [IDX_W:0]   rot_sum;
    logic [IDX_W-1:0] rot;

    assign accept  = i_start && (r_state == ST_IDLE);
    assign o_busy  = (r_state != ST_IDLE);
    assign rot_sum = {1'b0, r_idx} + {1'b0, r_root};
    assign rot     = (rot_sum >= (IDX_W+1)'(NUM_BINS))
                   ? IDX_W'(rot_sum - (IDX_W+1)'(NUM_BINS)) : IDX_W'(rot_sum);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept && i_last_bin && r_cnt == LAST_IDX) n_state = ST_SQR;
            ST_SQR:   n_state = ST_VAR;
            ST_VAR:   n_state = ST_DV;
            ST_DV:    if (r_step == DV_LAST) n_state = ST_MAC;
            ST_MAC:   if (r_idx == LAST_IDX) n_state = ST_NSQ;
            ST_NSQ:   n_state = ST_XINIT;
            ST_XINIT: n_state = ST_SRCH;
            ST_SRCH:  if (r_step == SRCH_LAST) n_state = ST_RANK;
            ST_RANK: begin
                if (r_mode && r_root == LAST_IDX) n_state = ST_CONF;
                else n_state = ST_MAC;
            end
            ST_CONF:  n_state = ST_EMIT;
            ST_EMIT:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op    = OP_NONE;
        o_cmd.addr  = '0;
        o_cmd.yidx  = r_idx;
        o_cmd.wr    = 1'b0;
        o_cmd.first = 1'b0;
        o_cmd.mode  = r_mode;
        o_cmd.root  = r_root;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.op    = (i_last_bin && r_cnt != LAST_IDX) ? OP_EMPTY : OP_LOAD;
                    o_cmd.addr  = r_cnt;
                    o_cmd.wr    = (r_cnt < IDX_W'(NUM_BINS));
                    o_cmd.first = (r_cnt == '0);
                end
            end
            ST_SQR:   o_cmd.op = OP_SQR;
            ST_VAR:   o_cmd.op = OP_VAR;
            ST_DV: begin
                o_cmd.op   = OP_DV;
                o_cmd.addr = r_step;
            end
            ST_MAC: begin
                o_cmd.op    = OP_MAC;
                o_cmd.addr  = rot;
                o_cmd.first = (r_idx == '0);
            end
            ST_NSQ:   o_cmd.op = OP_NSQ;
            ST_XINIT: o_cmd.op = OP_XINIT;
            ST_SRCH:  o_cmd.op = OP_SRCH;
            ST_RANK: begin
                o_cmd.op    = OP_RANK;
                o_cmd.first = !r_mode && (r_root == '0);
            end
            ST_CONF:  o_cmd.op = OP_CONF;
            ST_EMIT:  o_cmd.op = OP_EMIT;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_root  <= '0;
            r_mode  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                if (i_last_bin) r_cnt <= '0;
                else if (r_cnt < CNT_MAX) r_cnt <= r_cnt + 1'b1;
            end
            if ((r_state == ST_DV || r_state == ST_SRCH) && n_state == r_state) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
            if (r_state == ST_MAC && n_state == ST_MAC) r_idx <= r_idx + 1'b1;
            else r_idx <= '0;
            if (r_state == ST_DV) begin
                r_root <= '0;
                r_mode <= 1'b0;
            end else if (r_state == ST_RANK) begin
                if (r_root == LAST_IDX) begin
                    r_root <= '0;
                    r_mode <= 1'b1;
                end else begin
                    r_root <= r_root + 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/ckc_dp.sv @@
// ckc_dp: bin store, variance, correlation mac, score search, ranking and
// confidence; depends on ckc_pkg
module ckc_dp import ckc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic [BIN_WIDTH-1:0]      i_chroma_value,
    output logic                      o_strobe,
    output logic                      o_result_valid,
    output logic [IDX_W-1:0]          o_key_root,
    output logic                      o_key_mode,
    output logic signed [SCORE_W-1:0] o_best_score,
    output logic signed [SCORE_W-1:0] o_second_score,
    output logic [CONF_W-1:0]         o_confidence
);

    logic [BIN_WIDTH-1:0]      r_store [NUM_BINS];
    logic [SUM_W-1:0]          r_s;
    logic [SQ_W-1:0]           r_sq;
    logic [VAR_W-1:0]          r_s2, r_v;
    logic                      r_vzero;
    logic [M_W-1:0]            r_m [2];
    logic signed [N_W-1:0]     r_n;
    logic [2*NABS_W-1:0]       r_n2;
    logic signed [SRCH_W-1:0]  r_xt, r_a, r_bs, r_ms;
    logic [LO_W-1:0]           r_lo, r_mask;
    logic signed [RANK_W-1:0]  r_best, r_second;
    logic [IDX_W-1:0]          r_bi_root;
    logic                      r_bi_mode;
    logic                      r_wpos;
    logic [X_W-1:0]            r_cx;
    logic                      r_strobe, r_valid, r_mode_o;
    logic [IDX_W-1:0]          r_root_o;
    logic signed [SCORE_W-1:0] r_best_o, r_second_o;
    logic [CONF_W-1:0]         r_conf_o;

    logic [BIN_WIDTH-1:0]           c_rd;
    logic [2*BIN_WIDTH-1:0]         sq_in;
    logic signed [BIN_WIDTH+Y_W:0]  mac_prod;
    logic [D_W-1:0]                 d_sel;
    logic [HALF_W-1:0]              v_half;
    logic [D_W+HALF_W-1:0]          dv_prod;
    logic [VAR_W-1:0]               v_c;
    logic [N_W-1:0]                 n_mag;
    logic signed [SRCH_W-1:0]       x_val, m_ext, cand;
    logic                           take;
    logic signed [SCORE_W-1:0]      score;
    logic signed [RANK_W-1:0]       sc;
    logic signed [W_W-1:0]          w_c;
    logic [Q_W-1:0]                 wu, q_c;
    logic [X_W+RCP_W-4:0]           rcp_prod;
    logic [CONF_W-1:0]              conf_c;

    assign c_rd     = r_store[i_cmd.addr];
    assign sq_in    = i_chroma_value * i_chroma_value;
    assign mac_prod = $signed({1'b0, c_rd}) * prof_y(i_cmd.mode, i_cmd.yidx);
    assign d_sel    = i_cmd.addr[1] ? D_MIN : D_MAJ;
    assign v_half   = i_cmd.addr[0] ? r_v[VAR_W-1:HALF_W] : r_v[HALF_W-1:0];
    assign dv_prod  = d_sel * v_half;
    assign v_c      = (VAR_W'(r_sq) << 3) + (VAR_W'(r_sq) << 2) - r_s2;
    assign n_mag    = r_n[N_W-1] ? N_W'(-r_n) : N_W'(r_n);
    assign x_val    = $signed((SRCH_W'(r_n2) << (2*LO_W + 3))
                            + (SRCH_W'(r_n2) << (2*LO_W + 2)));
    assign m_ext    = $signed(SRCH_W'(r_m[i_cmd.mode]));
    assign cand     = r_a + r_bs + r_ms;
    assign take     = (cand <= r_xt);

    always_comb begin
        if (r_vzero) begin
            score = '0;
        end else if (r_n[N_W-1]) begin
            score = SCORE_W'(-$signed({1'b0, r_lo}));
        end else if (r_lo[LO_W-1]) begin
            score = {1'b0, {(SCORE_W-1){1'b1}}};
        end else begin
            score = $signed(r_lo);
        end
    end

    assign sc       = RANK_W'(score);
    assign w_c      = W_W'(r_best) * W_W'(43) - W_W'(r_second) * W_W'(40);
    assign wu       = Q_W'(w_c[W_W-2:0]);
    assign q_c      = (wu << 16) - wu + CONF_HALF;
    assign rcp_prod = r_cx[RCP_W-1:0] * RECIP5;

    always_comb begin
        if (!r_wpos) conf_c = '0;
        else if (r_cx >= CONF_SAT_X) conf_c = '1;
        else conf_c = rcp_prod[CONF_W+20:21];
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                if (i_cmd.wr) begin
                    r_store[i_cmd.addr] <= i_chroma_value;
                    if (i_cmd.first) begin
                        r_s  <= SUM_W'(i_chroma_value);
                        r_sq <= SQ_W'(sq_in);
                    end else begin
                        r_s  <= r_s + SUM_W'(i_chroma_value);
                        r_sq <= r_sq + SQ_W'(sq_in);
                    end
                end
            end
            OP_SQR: r_s2 <= VAR_W'(r_s * r_s);
            OP_VAR: begin
                r_v     <= v_c;
                r_vzero <= (v_c == '0);
            end
            OP_DV: begin
                if (!i_cmd.addr[0]) r_m[i_cmd.addr[1]] <= M_W'(dv_prod);
                else r_m[i_cmd.addr[1]] <= r_m[i_cmd.addr[1]] + (M_W'(dv_prod) << HALF_W);
            end
            OP_MAC: begin
                if (i_cmd.first) r_n <= N_W'(mac_prod);
                else r_n <= r_n + N_W'(mac_prod);
            end
            OP_NSQ: r_n2 <= n_mag[NABS_W-1:0] * n_mag[NABS_W-1:0];
            OP_XINIT: begin
                r_xt   <= x_val;
                r_a    <= m_ext;
                r_bs   <= -(m_ext <<< (LO_W + 1));
                r_ms   <= m_ext <<< (2*LO_W);
                r_lo   <= '0;
                r_mask <= {1'b1, {(LO_W-1){1'b0}}};
            end
            OP_SRCH: begin
                if (take) begin
                    r_a  <= cand;
                    r_bs <= (r_bs >>> 1) + r_ms;
                    r_lo <= r_lo | r_mask;
                end else begin
                    r_bs <= r_bs >>> 1;
                end
                r_ms   <= r_ms >>> 2;
                r_mask <= r_mask >> 1;
            end
            OP_RANK: begin
                if (i_cmd.first) begin
                    r_best    <= sc;
                    r_second  <= RANK_MIN;
                    r_bi_root <= i_cmd.root;
                    r_bi_mode <= i_cmd.mode;
                end else if (sc > r_best) begin
                    r_second  <= r_best;
                    r_best    <= sc;
                    r_bi_root <= i_cmd.root;
                    r_bi_mode <= i_cmd.mode;
                end else if (sc > r_second) begin
                    r_second <= sc;
                end
            end
            OP_CONF: begin
                r_wpos <= !w_c[W_W-1] && (w_c != '0);
                r_cx   <= q_c[X_W+15:16];
            end
            OP_EMPTY: begin
                r_valid    <= 1'b0;
                r_root_o   <= '0;
                r_mode_o   <= 1'b0;
                r_best_o   <= '0;
                r_second_o <= '0;
                r_conf_o   <= '0;
            end
            OP_EMIT: begin
                r_valid    <= 1'b1;
                r_root_o   <= r_bi_root;
                r_mode_o   <= r_bi_mode;
                r_best_o   <= r_best[SCORE_W-1:0];
                r_second_o <= r_second[SCORE_W-1:0];
                r_conf_o   <= conf_c;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.op == OP_EMPTY) || (i_cmd.op == OP_EMIT);
        end
    end

    assign o_strobe       = r_strobe;
    assign o_result_valid = r_valid;
    assign o_key_root     = r_root_o;
    assign o_key_mode     = r_mode_o;
    assign o_best_score   = r_best_o;
    assign o_second_score = r_second_o;
    assign o_confidence   = r_conf_o;

endmodule

@@ rtl/chroma_key_correlator_top.sv @@
// chroma_key_correlator_top: bins load one beat per cycle while busy is low
// a set not of twelve bins gives an invalid result in the cycle after its last beat
// a full set: busy while all 24 keys are correlated, then the result strobe
// each key takes a 12-step mac and a 16-step score search, after a variance setup
// synchronous active-low reset clears the sequencer, bin count and strobe
module chroma_key_correlator_top import ckc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [BIN_WIDTH-1:0]      i_chroma_value,
    input  logic                      i_last_bin,
    output logic                      o_strobe,
    output logic                      o_result_valid,
    output logic [IDX_W-1:0]          o_key_root,
    output logic                      o_key_mode,
    output logic signed [SCORE_W-1:0] o_best_score,
    output logic signed [SCORE_W-1:0] o_second_score,
    output logic [CONF_W-1:0]         o_confidence
);

    t_cmd cmd;

    ckc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_last_bin (i_last_bin),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    ckc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_chroma_value (i_chroma_value),
        .o_strobe       (o_strobe),
        .o_result_valid (o_result_valid),
        .o_key_root     (o_key_root),
        .o_key_mode     (o_key_mode),
        .o_best_score   (o_best_score),
        .o_second_score (o_second_score),
        .o_confidence   (o_confidence)
    );

endmodule
